[rtl/generational_handle_table_core_macros.svh]
// Assertion macros for the handle table core.
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define GHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define GHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/ght_pkg.sv]
// Package: types and constants of the handle table core.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;
    localparam int Slots = 32;
    localparam int IdxW = 5;
    localparam int CntW = 6;

    localparam logic [2:0] FN_REGISTER = 3'd0;
    localparam logic [2:0] FN_RETAIN = 3'd1;
    localparam logic [2:0] FN_MARK = 3'd2;
    localparam logic [2:0] FN_RELEASE = 3'd3;
    localparam logic [2:0] FN_COLLECT = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef enum logic [1:0] {
        SL_FREE = 2'd0,
        SL_ACTIVE = 2'd1,
        SL_RETIRED = 2'd2
    } t_slot_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_EX,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

[rtl/generational_handle_table_core.sv]
// Top level: generational handle table core.
// Usage:
//  - Input channel (i_valid/o_ready) carries one command: register, retain,
//    mark used, release or collect, with handle, type, tokens and sequence.
//  - Output channel (o_valid/i_ready) returns result transfers; o_last marks
//    the final result of a command.
//  - Register: the free-slot search walks the table slot by slot (read,
//    then check), then writes the first free slot; with no free slot the
//    result is exhausted.
//  - Retain, mark used, release: one table read then, on success, one write.
//  - Collect: walks every slot (read, then check and free), emitting one
//    result per freed slot, then a count result.
//  - Only one command is in flight; o_ready is high only when idle with no
//    result waiting, so a new command starts after the last result is taken.
//  - Slot payload memories are read at one shared address per cycle with
//    registered read data; the walk over them sets the command rate.
//  - Reset clears all slot states directly, and generations, counts and fences
//    through per-slot valid bits; no clearing pass is needed.
//  - A stalled receiver holds the result register and the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_table_core_macros.svh"
module generational_handle_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [63:0] i_handle,
    input  wire logic [7:0]  i_type_code,
    input  wire logic [31:0] i_resource_token,
    input  wire logic [15:0] i_destroy_token,
    input  wire logic [63:0] i_sequence_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [63:0]      o_new_handle,
    output logic [31:0]      o_found_token,
    output logic [15:0]      o_freed_destroy,
    output logic [5:0]       o_collected_count,
    output logic             o_last
);
    // per-slot control state in flops (reset-cleared); payload in memories
    ght_pkg::t_slot_state r_sstate [ght_pkg::Slots];
    logic [ght_pkg::Slots-1:0] r_wr;  // slot's gen/refs/type/fence written
    logic [31:0] m_gen   [ght_pkg::Slots];
    logic [31:0] m_refs  [ght_pkg::Slots];
    logic [7:0]  m_type  [ght_pkg::Slots];
    logic [63:0] m_fence [ght_pkg::Slots];
    logic [31:0] m_tok   [ght_pkg::Slots];
    logic [15:0] m_dst   [ght_pkg::Slots];
    logic [5:0]  r_used;

    ght_pkg::t_state r_state, n_state;
    logic [2:0]  r_func;
    logic [63:0] r_handle, r_seq;
    logic [7:0]  r_type;
    logic [31:0] r_tok;
    logic [15:0] r_dst;
    logic [ght_pkg::IdxW-1:0] r_idx, n_idx;
    logic [ght_pkg::CntW-1:0] r_cnt, n_cnt;
    logic        r_hok, n_hok;
    // registered read data
    logic [31:0] r_gen_q, r_refs_q, r_tok_q;
    logic [7:0]  r_type_q;
    logic [63:0] r_fence_q;
    logic [15:0] r_dst_q;
    logic        r_wr_q;
    // write port
    logic        w_en;
    logic [31:0] w_gen, w_refs;
    logic [7:0]  w_type;
    logic [63:0] w_fence;
    logic        w_pay;
    ght_pkg::t_slot_state w_st;
    logic        w_used_inc, w_used_dec;
    // output register
    logic        r_ov, n_ov;
    logic [1:0]  r_st, n_st;
    logic [63:0] r_nh, n_nh;
    logic [31:0] r_ft, n_ft;
    logic [15:0] r_fd, n_fd;
    logic [5:0]  r_cc, n_cc;
    logic        r_la, n_la;

    logic [31:0] g_eff, gen_in, low_in, refs_eff;
    logic [7:0]  type_eff;
    logic [63:0] fence_eff;
    ght_pkg::t_slot_state cur_st;
    logic        handle_ok, pick;

    assign o_ready = (r_state == ght_pkg::S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_new_handle = r_nh;
    assign o_found_token = r_ft;
    assign o_freed_destroy = r_fd;
    assign o_collected_count = r_cc;
    assign o_last = r_la;

    assign gen_in = r_handle[63:32];
    assign low_in = r_handle[31:0];
    assign g_eff = r_wr_q ? r_gen_q : 32'd0;
    assign refs_eff = r_wr_q ? r_refs_q : 32'd0;
    assign type_eff = r_wr_q ? r_type_q : 8'd0;
    assign fence_eff = r_wr_q ? r_fence_q : 64'd0;
    assign cur_st = r_sstate[r_idx];
    assign handle_ok = r_hok && (cur_st != ght_pkg::SL_FREE) && (g_eff == gen_in);
    assign pick = (cur_st == ght_pkg::SL_RETIRED) && (fence_eff <= r_seq);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_cnt = r_cnt;
        n_hok = r_hok;
        n_ov = r_ov;
        n_st = r_st;
        n_nh = r_nh;
        n_ft = r_ft;
        n_fd = r_fd;
        n_cc = r_cc;
        n_la = r_la;
        w_en = 1'b0;
        w_gen = g_eff;
        w_refs = refs_eff;
        w_type = type_eff;
        w_fence = fence_eff;
        w_pay = 1'b0;
        w_st = cur_st;
        w_used_inc = 1'b0;
        w_used_dec = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            ght_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_idx = i_handle[ght_pkg::IdxW-1:0] - 1'b1;
                    n_hok = (i_handle[31:0] != 32'd0) && (i_handle[63:32] != 32'd0)
                        && ((i_handle[31:0] - 32'd1) < 32'(ght_pkg::Slots));
                    n_cnt = '0;
                    if (i_func == ght_pkg::FN_REGISTER || i_func == ght_pkg::FN_COLLECT)
                        n_idx = '0;
                    n_state = ght_pkg::S_READ;
                end
            end
            ght_pkg::S_READ: n_state = ght_pkg::S_EXEC;
            ght_pkg::S_EXEC: begin
                n_st = ght_pkg::ST_INVALID;
                n_nh = '0;
                n_ft = '0;
                n_fd = '0;
                n_cc = '0;
                n_la = 1'b1;
                n_state = ght_pkg::S_OUT;
                case (r_func)
                    ght_pkg::FN_REGISTER: begin
                        if (r_type == 8'd0 || r_tok == 32'd0) begin
                            n_st = ght_pkg::ST_INVALID;
                        end else if (cur_st == ght_pkg::SL_FREE) begin
                            w_en = 1'b1;
                            w_pay = 1'b1;
                            w_gen = (g_eff == 32'd0) ? 32'd1 : g_eff;
                            w_refs = 32'd1;
                            w_type = r_type;
                            w_fence = '0;
                            w_st = ght_pkg::SL_ACTIVE;
                            w_used_inc = 1'b1;
                            n_st = ght_pkg::ST_OK;
                            n_nh = {w_gen, 32'({1'b0, r_idx} + 6'd1)};
                        end else if (32'(r_idx) == 32'(ght_pkg::Slots - 1)) begin
                            n_st = ght_pkg::ST_EXHAUSTED;
                        end else begin
                            n_idx = r_idx + 1'b1;
                            n_state = ght_pkg::S_READ;
                        end
                    end
                    ght_pkg::FN_RETAIN: begin
                        if (!handle_ok || cur_st != ght_pkg::SL_ACTIVE
                            || (r_type != 8'd0 && type_eff != r_type)) begin
                            n_st = ght_pkg::ST_INVALID;
                        end else if (refs_eff == 32'hFFFF_FFFF) begin
                            n_st = ght_pkg::ST_EXHAUSTED;
                        end else begin
                            w_en = 1'b1;
                            w_refs = refs_eff + 32'd1;
                            n_st = ght_pkg::ST_OK;
                            n_ft = r_tok_q;
                        end
                    end
                    ght_pkg::FN_MARK: begin
                        if (r_seq == 64'd0 || !handle_ok || cur_st != ght_pkg::SL_ACTIVE) begin
                            n_st = ght_pkg::ST_INVALID;
                        end else begin
                            w_en = 1'b1;
                            if (r_seq > fence_eff) w_fence = r_seq;
                            n_st = ght_pkg::ST_OK;
                        end
                    end
                    ght_pkg::FN_RELEASE: begin
                        if (!handle_ok || refs_eff == 32'd0) begin
                            n_st = ght_pkg::ST_INVALID;
                        end else begin
                            w_en = 1'b1;
                            w_refs = refs_eff - 32'd1;
                            if (refs_eff == 32'd1) w_st = ght_pkg::SL_RETIRED;
                            n_st = ght_pkg::ST_OK;
                        end
                    end
                    ght_pkg::FN_COLLECT: begin
                        n_la = 1'b0;
                        n_state = ght_pkg::S_SCAN_EX;
                    end
                    default: n_st = ght_pkg::ST_INVALID;
                endcase
            end
            ght_pkg::S_SCAN_RD: n_state = ght_pkg::S_SCAN_EX;
            ght_pkg::S_SCAN_EX: begin
                if (!r_ov || i_ready) begin
                    if (pick) begin
                        w_en = 1'b1;
                        w_gen = (g_eff == 32'hFFFF_FFFF) ? 32'd1 : g_eff + 32'd1;
                        w_refs = '0;
                        w_type = '0;
                        w_fence = '0;
                        w_st = ght_pkg::SL_FREE;
                        w_used_dec = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        n_ov = 1'b1;
                        n_st = ght_pkg::ST_OK;
                        n_nh = '0;
                        n_ft = r_tok_q;
                        n_fd = r_dst_q;
                        n_cc = '0;
                        n_la = 1'b0;
                    end
                    if (32'(r_idx) == 32'(ght_pkg::Slots - 1)) begin
                        n_st = pick ? n_st : ght_pkg::ST_OK;
                        n_state = pick ? ght_pkg::S_EXEC : ght_pkg::S_OUT;
                        if (!pick) begin
                            n_nh = '0; n_ft = '0; n_fd = '0;
                            n_cc = n_cnt; n_la = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = ght_pkg::S_SCAN_RD;
                    end
                end
            end
            ght_pkg::S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_state = ght_pkg::S_IDLE;
                    if (r_func == ght_pkg::FN_COLLECT && !r_la) begin
                        // final count after the last slot was freed
                        n_st = ght_pkg::ST_OK;
                        n_nh = '0; n_ft = '0; n_fd = '0;
                        n_cc = r_cnt; n_la = 1'b1;
                    end
                end
            end
            default: n_state = ght_pkg::S_IDLE;
        endcase
        // collect's last slot freed: EXEC reentry sends it to the count result
        if (r_state == ght_pkg::S_EXEC && r_func == ght_pkg::FN_COLLECT && r_idx != '0) begin
            n_st = r_st; n_nh = r_nh; n_ft = r_ft; n_fd = r_fd; n_cc = r_cc;
            n_la = 1'b0;
            n_state = ght_pkg::S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ght_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_used <= '0;
            r_wr <= '0;
            r_idx <= '0;
            r_cnt <= '0;
            r_hok <= 1'b0;
            r_la <= 1'b0;
            for (int k = 0; k < ght_pkg::Slots; k++) r_sstate[k] <= ght_pkg::SL_FREE;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            r_hok <= n_hok;
            r_la <= n_la;
            if (w_en) begin
                r_sstate[r_idx] <= w_st;
                r_wr[r_idx] <= 1'b1;
            end
            if (w_used_inc) r_used <= r_used + 1'b1;
            else if (w_used_dec) r_used <= r_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        r_nh <= n_nh;
        r_ft <= n_ft;
        r_fd <= n_fd;
        r_cc <= n_cc;
        if (i_valid && o_ready) begin
            r_func <= i_func;
            r_handle <= i_handle;
            r_type <= i_type_code;
            r_tok <= i_resource_token;
            r_dst <= i_destroy_token;
            r_seq <= i_sequence_req;
        end
        r_gen_q <= m_gen[r_idx];
        r_refs_q <= m_refs[r_idx];
        r_type_q <= m_type[r_idx];
        r_fence_q <= m_fence[r_idx];
        r_tok_q <= m_tok[r_idx];
        r_dst_q <= m_dst[r_idx];
        r_wr_q <= r_wr[r_idx];
        if (w_en) begin
            m_gen[r_idx] <= w_gen;
            m_refs[r_idx] <= w_refs;
            m_type[r_idx] <= w_type;
            m_fence[r_idx] <= w_fence;
            if (w_pay) begin
                m_tok[r_idx] <= r_tok;
                m_dst[r_idx] <= r_dst;
            end
        end
    end

    `GHT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !w_en, "write while idle")
    `GHT_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status), "output dropped")
    `GHT_ASSERT_IMP(a_used, i_clk, i_rst_n, w_used_inc, r_used < 6'(ght_pkg::Slots), "used overflow")
    `GHT_ASSERT_IMP(a_nofree_dec, i_clk, i_rst_n, w_used_dec, r_used != 6'd0, "used underflow")
endmodule
`default_nettype wire

[verif/ght_result_checker.sv]
// Checker for the handle table core: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module ght_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [2:0]  i_func,
    input  logic [63:0] i_handle,
    input  logic [7:0]  i_type_code,
    input  logic [31:0] i_resource_token,
    input  logic [15:0] i_destroy_token,
    input  logic [63:0] i_sequence_req,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [63:0] i_new_handle,
    input  logic [31:0] i_found_token,
    input  logic [15:0] i_freed_destroy,
    input  logic [5:0]  i_collected_count,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] new_handle;
        logic [31:0] found_token;
        logic [15:0] freed_destroy;
        logic [5:0]  collected_count;
        logic        last;
    } t_result;

    t_result     expected_results[$];
    ght_pkg::t_slot_state tbl_state [ght_pkg::Slots];
    logic [31:0] tbl_gen   [ght_pkg::Slots];
    logic [31:0] tbl_refs  [ght_pkg::Slots];
    logic [7:0]  tbl_type  [ght_pkg::Slots];
    logic [63:0] tbl_fence [ght_pkg::Slots];
    logic [31:0] tbl_token [ght_pkg::Slots];
    logic [15:0] tbl_dtor  [ght_pkg::Slots];

    function automatic t_result mk(logic [1:0] st, logic [63:0] nh = '0, logic [31:0] tok = '0,
                                   logic [15:0] dt = '0, logic [5:0] cnt = '0,
                                   logic lst = 1'b1);
        t_result r;
        r.status = st; r.new_handle = nh; r.found_token = tok;
        r.freed_destroy = dt; r.collected_count = cnt; r.last = lst;
        return r;
    endfunction

    // Slot index of a live handle, or -1.
    function automatic int find_slot(logic [63:0] h);
        logic [31:0] lo;
        logic [31:0] gen;
        lo = h[31:0];
        gen = h[63:32];
        if (lo == 0 || gen == 0 || (lo - 1) >= ght_pkg::Slots) return -1;
        if (tbl_state[lo-1] == ght_pkg::SL_FREE || tbl_gen[lo-1] != gen) return -1;
        return int'(lo - 1);
    endfunction

    task automatic predict_command();
        int s;
        int n;
        s = -1;
        case (i_func)
            ght_pkg::FN_REGISTER: begin
                if (i_type_code == 0 || i_resource_token == 0) begin
                    expected_results.push_back(mk(ght_pkg::ST_INVALID));
                end else begin
                    for (int i = 0; i < ght_pkg::Slots; i++) begin
                        if (tbl_state[i] == ght_pkg::SL_FREE) begin
                            s = i;
                            break;
                        end
                    end
                    if (s < 0) begin
                        expected_results.push_back(mk(ght_pkg::ST_EXHAUSTED));
                    end else begin
                        if (tbl_gen[s] == 0) tbl_gen[s] = 1;
                        tbl_token[s] = i_resource_token;
                        tbl_dtor[s] = i_destroy_token;
                        tbl_fence[s] = 0;
                        tbl_refs[s] = 1;
                        tbl_type[s] = i_type_code;
                        tbl_state[s] = ght_pkg::SL_ACTIVE;
                        expected_results.push_back(mk(ght_pkg::ST_OK,
                                                      {tbl_gen[s], 32'(s + 1)}));
                    end
                end
            end
            ght_pkg::FN_RETAIN: begin
                s = find_slot(i_handle);
                if (s < 0 || tbl_state[s] != ght_pkg::SL_ACTIVE ||
                    (i_type_code != 0 && tbl_type[s] != i_type_code))
                    expected_results.push_back(mk(ght_pkg::ST_INVALID));
                else if (tbl_refs[s] == 32'hFFFF_FFFF)
                    expected_results.push_back(mk(ght_pkg::ST_EXHAUSTED));
                else begin
                    tbl_refs[s]++;
                    expected_results.push_back(mk(ght_pkg::ST_OK, '0, tbl_token[s]));
                end
            end
            ght_pkg::FN_MARK: begin
                s = find_slot(i_handle);
                if (i_sequence_req == 0 || s < 0 || tbl_state[s] != ght_pkg::SL_ACTIVE)
                    expected_results.push_back(mk(ght_pkg::ST_INVALID));
                else begin
                    if (i_sequence_req > tbl_fence[s]) tbl_fence[s] = i_sequence_req;
                    expected_results.push_back(mk(ght_pkg::ST_OK));
                end
            end
            ght_pkg::FN_RELEASE: begin
                s = find_slot(i_handle);
                if (s < 0 || tbl_refs[s] == 0)
                    expected_results.push_back(mk(ght_pkg::ST_INVALID));
                else begin
                    tbl_refs[s]--;
                    if (tbl_refs[s] == 0) tbl_state[s] = ght_pkg::SL_RETIRED;
                    expected_results.push_back(mk(ght_pkg::ST_OK));
                end
            end
            ght_pkg::FN_COLLECT: begin
                n = 0;
                for (int i = 0; i < ght_pkg::Slots; i++) begin
                    if (tbl_state[i] == ght_pkg::SL_RETIRED &&
                        tbl_fence[i] <= i_sequence_req) begin
                        expected_results.push_back(mk(ght_pkg::ST_OK, '0, tbl_token[i],
                                                      tbl_dtor[i], '0, 1'b0));
                        n++;
                        tbl_fence[i] = 0;
                        tbl_refs[i] = 0;
                        tbl_type[i] = 0;
                        tbl_state[i] = ght_pkg::SL_FREE;
                        tbl_gen[i] = (tbl_gen[i] == 32'hFFFF_FFFF) ? 32'd1 : tbl_gen[i] + 1;
                    end
                end
                expected_results.push_back(mk(ght_pkg::ST_OK, '0, '0, '0, 6'(n)));
            end
            default: expected_results.push_back(mk(ght_pkg::ST_INVALID));
        endcase
    endtask

    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors <= 0;
            for (int i = 0; i < ght_pkg::Slots; i++) begin
                tbl_state[i] = ght_pkg::SL_FREE;
                tbl_gen[i] = 0;
                tbl_refs[i] = 0;
                tbl_type[i] = 0;
                tbl_fence[i] = 0;
                tbl_token[i] = 0;
                tbl_dtor[i] = 0;
            end
        end else begin
            // Output first: a result can never belong to the command accepted this edge.
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_new_handle, i_found_token, i_freed_destroy,
                       i_collected_count, i_last};
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result transfer %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: exp st=%0d nh=%h tok=%h dt=%h cnt=%0d last=%b",
                                     want.status, want.new_handle, want.found_token,
                                     want.freed_destroy, want.collected_count, want.last,
                                     "\n          got st=%0d nh=%h tok=%h dt=%h cnt=%0d last=%b",
                                     got.status, got.new_handle, got.found_token,
                                     got.freed_destroy, got.collected_count, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) predict_command();
        end
        o_pending <= expected_results.size();
    end
endmodule

[verif/tb_generational_handle_table_core.sv]
// Testbench top for the handle table core: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_generational_handle_table_core;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [63:0] i_handle = '0;
    logic [7:0]  i_type_code = '0;
    logic [31:0] i_resource_token = '0;
    logic [15:0] i_destroy_token = '0;
    logic [63:0] i_sequence_req = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_new_handle;
    logic [31:0] o_found_token;
    logic [15:0] o_freed_destroy;
    logic [5:0]  o_collected_count;
    logic        o_last;
    int          mismatch_count;
    int          results_outstanding;

    // Handles handed out by register, harvested from output transfers.
    logic [63:0] issued_handles[$];
    logic        stall_enable = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    generational_handle_table_core dut (.*);

    ght_result_checker checker_u (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_func, .i_handle,
        .i_type_code, .i_resource_token, .i_destroy_token, .i_sequence_req,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_status(o_status),
        .i_new_handle(o_new_handle),
        .i_found_token(o_found_token), .i_freed_destroy(o_freed_destroy),
        .i_collected_count(o_collected_count), .i_last(o_last),
        .o_errors(mismatch_count), .o_pending(results_outstanding)
    );

    // Receiver: stall pattern of its own; a free-running phase counter
    // and random draws decide stalls, with long ready-only stretches mixed in.
    int rx_phase = 0;
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (!stall_enable || (rx_phase % 97) < 30)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 3) != 0) && ((rx_phase % 7) != 3);
        if (o_valid && i_ready && o_status == ght_pkg::ST_OK && o_new_handle != 0)
            issued_handles.push_back(o_new_handle);
    end

    // Drives one command and holds it until the transfer happens.
    task automatic send(logic [2:0] fn, logic [63:0] h, logic [7:0] ty, logic [31:0] tok,
                        logic [15:0] dt, logic [63:0] sq);
        i_valid <= 1'b1;
        i_func <= fn;
        i_handle <= h;
        i_type_code <= ty;
        i_resource_token <= tok;
        i_destroy_token <= dt;
        i_sequence_req <= sq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        @(posedge i_clk);
        while (results_outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_handle();
        if (issued_handles.size() == 0 || $urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return issued_handles[$urandom_range(0, issued_handles.size() - 1)];
    endfunction

    // Well-formed traffic mostly, with some garbage handles and bad codes.
    task automatic send_random();
        int r;
        logic [2:0] fn;
        logic [63:0] h;
        logic [63:0] sq;
        r = $urandom_range(0, 99);
        h = pick_handle();
        if (r < 5) h[31:0] = $urandom_range(0, 40);
        sq = (r % 3 == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 50));
        if (r < 28) fn = ght_pkg::FN_REGISTER;
        else if (r < 45) fn = ght_pkg::FN_RETAIN;
        else if (r < 58) fn = ght_pkg::FN_MARK;
        else if (r < 82) fn = ght_pkg::FN_RELEASE;
        else if (r < 97) fn = ght_pkg::FN_COLLECT;
        else fn = 3'($urandom_range(5, 7));
        send(fn, h, ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
             ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom, 16'($urandom), sq);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad register arguments, unknown codes, empty-table ops.
        send(ght_pkg::FN_REGISTER, '0, 8'd0, 32'd5, 16'd1, '0);
        send(ght_pkg::FN_REGISTER, '0, 8'd3, 32'd0, 16'd1, '0);
        send(3'd5, '1, '1, '1, '1, '1);
        send(3'd7, '0, '0, '0, '0, '0);
        send(ght_pkg::FN_RETAIN, 64'h0000_0001_0000_0001, 8'd0, '0, '0, '0);
        send(ght_pkg::FN_COLLECT, '0, '0, '0, '0, '1);
        // Fill the table past capacity with extreme tokens.
        for (int i = 0; i < ght_pkg::Slots + 1; i++)
            send(ght_pkg::FN_REGISTER, '0, (i == 0) ? 8'hFF : 8'(i + 1),
                 (i == 0) ? 32'hFFFF_FFFF : 32'(i + 100), (i == 0) ? 16'hFFFF : 16'(i), '0);
        drain();
        // Fence, type mismatch, zero sequence, release to retired, fenced collect.
        send(ght_pkg::FN_MARK, 64'h0000_0001_0000_0001, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(ght_pkg::FN_MARK, 64'h0000_0001_0000_0001, '0, '0, '0, 64'd0);
        send(ght_pkg::FN_RETAIN, 64'h0000_0001_0000_0001, 8'd7, '0, '0, '0);
        send(ght_pkg::FN_RETAIN, 64'h0000_0001_0000_0001, 8'hFF, '0, '0, '0);
        send(ght_pkg::FN_RELEASE, 64'h0000_0001_0000_0001, '0, '0, '0, '0);
        send(ght_pkg::FN_RELEASE, 64'h0000_0001_0000_0001, '0, '0, '0, '0);
        send(ght_pkg::FN_RETAIN, 64'h0000_0001_0000_0001, 8'd0, '0, '0, '0);
        send(ght_pkg::FN_RELEASE, 64'h0000_0001_0000_0002, '0, '0, '0, '0);
        send(ght_pkg::FN_RELEASE, 64'h0000_0001_0000_0021, '0, '0, '0, '0);
        send(ght_pkg::FN_COLLECT, '0, '0, '0, '0, 64'd10);
        send(ght_pkg::FN_COLLECT, '0, '0, '0, '0, '1);
        send(ght_pkg::FN_RELEASE, 64'h0000_0001_0000_0001, '0, '0, '0, '0);
        drain();
        issued_handles.delete();

        // Random: bursts with gaps; stalls on; full drains midway.
        stall_enable <= 1'b1;
        for (int n = 0; n < 220;) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) begin
                send_random();
                // Keep the handle list bounded: drop the oldest handles now and then.
                if (issued_handles.size() > 60) issued_handles = issued_handles[30:$];
            end
            go_idle();
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            if (n > 130 && n < 143) drain();
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("tb_generational_handle_table_core: done, clean");
        else
            $display("tb_generational_handle_table_core: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_generational_handle_table_core: done, errors");
        $finish;
    end
endmodule
